FILE: src/pwtc_pkg.sv
// ----------------------------------------------------------------------------
// pwtc_pkg
// Shared types and constants for the pulse width to channel value scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package pwtc_pkg;

    localparam int NUM_INPUTS   = 8;
    localparam int CHANNEL_LOW  = 172;
    localparam int CHANNEL_HIGH = 1811;

    localparam int DIV_BITS = 12;
    localparam int NUM_BITS = 23;

    localparam logic [10:0] CH_LOW   = 11'(CHANNEL_LOW);
    localparam logic [10:0] CH_HIGH  = 11'(CHANNEL_HIGH);
    localparam logic [10:0] CH_SPAN  = 11'(CHANNEL_HIGH - CHANNEL_LOW);
    localparam logic [10:0] CH_MID   = 11'((CHANNEL_LOW + CHANNEL_HIGH + 1) / 2);

    typedef enum logic [2:0] {
        REG_PULSE_MIN        = 3'd0,
        REG_PULSE_MAX        = 3'd1,
        REG_INVERT_ENABLES   = 3'd2,
        REG_DEADBAND_ENABLES = 3'd3,
        REG_DEADBAND_WIDTH   = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic        byp;
        logic        below;
        logic [15:0] val;
        logic [11:0] centre;
    } side_t;

    typedef struct packed {
        logic                    valid;
        logic [DIV_BITS-1:0]     rem;
        logic [DIV_BITS-1:0]     nq;
        logic [DIV_BITS-1:0]     den;
        side_t                   side;
    } div_word_t;

endpackage

`default_nettype wire

FILE: src/pwtc_div_cell.sv
// ----------------------------------------------------------------------------
// pwtc_div_cell
// One restoring division step: shifts in a numerator bit, makes a quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module pwtc_div_cell (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire pwtc_pkg::div_word_t   word_in,
    output pwtc_pkg::div_word_t        word_out
);

    pwtc_pkg::div_word_t word_reg;
    pwtc_pkg::div_word_t word_next;
    logic [pwtc_pkg::DIV_BITS:0] trial;
    logic                        ge;

    always_comb
    begin
        trial = {word_in.rem, word_in.nq[pwtc_pkg::DIV_BITS-1]};
        ge    = trial >= {1'b0, word_in.den};
        word_next = word_in;
        if (ge)
        begin
            word_next.rem = pwtc_pkg::DIV_BITS'(trial - {1'b0, word_in.den});
        end
        else
        begin
            word_next.rem = trial[pwtc_pkg::DIV_BITS-1:0];
        end
        word_next.nq = {word_in.nq[pwtc_pkg::DIV_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else if (en)
        begin
            word_reg <= word_next;
        end
    end

    assign word_out = word_reg;

endmodule

`default_nettype wire

FILE: src/pwtc_div_chain.sv
// ----------------------------------------------------------------------------
// pwtc_div_chain
// Row of division cells, one quotient bit per cell, one word per clock while en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module pwtc_div_chain (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire pwtc_pkg::div_word_t   word_in,
    output pwtc_pkg::div_word_t        word_out
);

    pwtc_pkg::div_word_t link [0:pwtc_pkg::DIV_BITS];

    assign link[0] = word_in;

    for (genvar i = 0; i < pwtc_pkg::DIV_BITS; i++)
    begin : g_cell
        pwtc_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .word_in  (link[i]),
            .word_out (link[i+1])
        );
    end

    assign word_out = link[pwtc_pkg::DIV_BITS];

endmodule

`default_nettype wire

FILE: src/pwm_width_to_channel_value.sv
// ----------------------------------------------------------------------------
// pwm_width_to_channel_value
// Converts a measured PWM pulse width into an RC channel value.
// ----------------------------------------------------------------------------
// Takes one word per clock while the skid register is empty and returns one
// channel value per word, in order. Each word passes through two 12-cell
// division chains (deadband stretch, then linear scaling), each producing one
// quotient bit per cell, plus five staging registers and the output register.
// A skid register on the output catches one finished word while the output
// waits; while it is full, in_ready and the whole pipeline are held.
// Registers must be written only while no word is in flight.
`default_nettype none

module pwm_width_to_channel_value (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        write_enable,
    input  wire logic [2:0]  write_index,
    input  wire logic [11:0] write_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  input_index,
    input  wire logic [15:0] pulse_width,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [10:0]      channel_value
);

    logic [11:0] pulse_min_reg;
    logic [11:0] pulse_max_reg;
    logic [7:0]  invert_enables_reg;
    logic [7:0]  deadband_enables_reg;
    logic [11:0] deadband_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_min_reg        <= 12'd1000;
            pulse_max_reg        <= 12'd2000;
            invert_enables_reg   <= '0;
            deadband_enables_reg <= '0;
            deadband_width_reg   <= '0;
        end
        else if (write_enable)
        begin
            unique case (write_index)
                pwtc_pkg::REG_PULSE_MIN:        pulse_min_reg        <= write_data;
                pwtc_pkg::REG_PULSE_MAX:        pulse_max_reg        <= write_data;
                pwtc_pkg::REG_INVERT_ENABLES:   invert_enables_reg   <= write_data[7:0];
                pwtc_pkg::REG_DEADBAND_ENABLES: deadband_enables_reg <= write_data[7:0];
                pwtc_pkg::REG_DEADBAND_WIDTH:   deadband_width_reg   <= write_data;
                default: ;
            endcase
        end
    end

    // static values derived from the registers
    logic        empty;
    logic [12:0] sum;
    logic [11:0] centre;
    logic [11:0] span_in;
    logic [10:0] half;

    assign empty   = pulse_max_reg <= pulse_min_reg;
    assign sum     = {1'b0, pulse_min_reg} + {1'b0, pulse_max_reg};
    assign centre  = sum[12:1];
    assign span_in = pulse_max_reg - pulse_min_reg;
    assign half    = span_in[11:1];

    logic en;
    logic skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign in_ready = en;

    // stage A: mirror and deadband decision
    logic        sel_inv;
    logic        sel_db;
    logic [15:0] w1;
    logic        a_below;
    logic [15:0] a_mag;
    logic        a_apply;
    logic        a_snap;

    always_comb
    begin
        sel_inv = (32'(input_index) < pwtc_pkg::NUM_INPUTS) && invert_enables_reg[input_index];
        sel_db  = (32'(input_index) < pwtc_pkg::NUM_INPUTS) && deadband_enables_reg[input_index];
        if (sel_inv)
        begin
            w1 = ({3'b0, sum} > pulse_width) ? ({3'b0, sum} - pulse_width) : 16'd0;
        end
        else
        begin
            w1 = pulse_width;
        end
        a_below = w1 < {4'b0, centre};
        a_mag   = a_below ? ({4'b0, centre} - w1) : (w1 - {4'b0, centre});
        a_apply = sel_db && (deadband_width_reg != 12'd0) && !empty;
        a_snap  = (a_mag <= {4'b0, deadband_width_reg}) || (deadband_width_reg >= {1'b0, half});
    end

    logic        a_valid_reg;
    logic        a_byp_reg;
    logic        a_below_reg;
    logic [15:0] a_val_reg;
    logic [15:0] a_dm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_byp_reg   <= 1'b0;
            a_below_reg <= 1'b0;
            a_val_reg   <= '0;
            a_dm_reg    <= '0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            a_byp_reg   <= !a_apply || a_snap;
            a_below_reg <= a_below;
            a_val_reg   <= a_apply ? {4'b0, centre} : w1;
            a_dm_reg    <= a_mag - {4'b0, deadband_width_reg};
        end
    end

    // stage B: stretch numerator, travel clamped at twice span_db
    logic [10:0] span_db;
    logic [11:0] span_x2;
    logic [11:0] dclamp;
    logic [22:0] num1;
    pwtc_pkg::div_word_t b_next;
    pwtc_pkg::div_word_t b_reg;

    always_comb
    begin
        span_db = half - deadband_width_reg[10:0];
        span_x2 = {span_db, 1'b0};
        dclamp  = (a_dm_reg > {4'b0, span_x2}) ? span_x2 : a_dm_reg[11:0];
        num1    = 23'(dclamp) * 23'(half) + 23'(span_db[10:1]);
        b_next.valid       = a_valid_reg;
        b_next.rem         = {1'b0, num1[22:12]};
        b_next.nq          = num1[11:0];
        b_next.den         = {1'b0, span_db};
        b_next.side.byp    = a_byp_reg;
        b_next.side.below  = a_below_reg;
        b_next.side.val    = a_val_reg;
        b_next.side.centre = centre;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= '0;
        end
        else if (en)
        begin
            b_reg <= b_next;
        end
    end

    pwtc_pkg::div_word_t c1_out;

    pwtc_div_chain u_stretch (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .word_in  (b_reg),
        .word_out (c1_out)
    );

    // stage C: width after deadband
    logic [15:0] w2;
    logic        c_valid_reg;
    logic [15:0] c_w_reg;

    always_comb
    begin
        if (c1_out.side.byp)
        begin
            w2 = c1_out.side.val;
        end
        else if (c1_out.side.below)
        begin
            w2 = (c1_out.nq > c1_out.side.centre) ? 16'd0
                : {4'b0, c1_out.side.centre - c1_out.nq};
        end
        else
        begin
            w2 = {4'b0, c1_out.side.centre} + {4'b0, c1_out.nq};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            c_w_reg     <= '0;
        end
        else if (en)
        begin
            c_valid_reg <= c1_out.valid;
            c_w_reg     <= w2;
        end
    end

    // stage D: scaling numerator, with bypass to the mid, low or high value
    logic [11:0] offset;
    logic [22:0] num2;
    pwtc_pkg::div_word_t d_next;
    pwtc_pkg::div_word_t d_reg;

    always_comb
    begin
        offset = 12'(c_w_reg - {4'b0, pulse_min_reg});
        num2   = 23'(offset) * 23'(pwtc_pkg::CH_SPAN) + 23'(span_in[11:1]);
        d_next.valid       = c_valid_reg;
        d_next.rem         = {1'b0, num2[22:12]};
        d_next.nq          = num2[11:0];
        d_next.den         = span_in;
        d_next.side.below  = 1'b0;
        d_next.side.centre = '0;
        priority if (empty)
        begin
            d_next.side.byp = 1'b1;
            d_next.side.val = {5'b0, pwtc_pkg::CH_MID};
        end
        else if (c_w_reg <= {4'b0, pulse_min_reg})
        begin
            d_next.side.byp = 1'b1;
            d_next.side.val = {5'b0, pwtc_pkg::CH_LOW};
        end
        else if (c_w_reg >= {4'b0, pulse_max_reg})
        begin
            d_next.side.byp = 1'b1;
            d_next.side.val = {5'b0, pwtc_pkg::CH_HIGH};
        end
        else
        begin
            d_next.side.byp = 1'b0;
            d_next.side.val = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg <= '0;
        end
        else if (en)
        begin
            d_reg <= d_next;
        end
    end

    pwtc_pkg::div_word_t c2_out;

    pwtc_div_chain u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .word_in  (d_reg),
        .word_out (c2_out)
    );

    // stage E: final value
    logic        e_valid_reg;
    logic [10:0] e_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            e_value_reg <= '0;
        end
        else if (en)
        begin
            e_valid_reg <= c2_out.valid;
            e_value_reg <= c2_out.side.byp ? c2_out.side.val[10:0]
                : pwtc_pkg::CH_LOW + c2_out.nq[10:0];
        end
    end

    // output register with skid
    logic        out_valid_reg;
    logic [10:0] out_value_reg;
    logic [10:0] skid_value_reg;
    logic        incoming;

    assign incoming = e_valid_reg && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_value_reg  <= '0;
            skid_value_reg <= '0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                out_value_reg  <= skid_value_reg;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= incoming;
                out_value_reg <= e_value_reg;
            end
        end
        else if (incoming)
        begin
            skid_valid_reg <= 1'b1;
            skid_value_reg <= e_value_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign channel_value = out_value_reg;

endmodule

`default_nettype wire
